### hw/rtl/nrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Newton-Raphson divider package
// Widths, constants, the reciprocal seed table and the sideband word type
// shared by the divider pipeline and its refinement stages.
// ----------------------------------------------------------------------------
package nrd_pkg;

  localparam int NUM_W     = 23;  // signed numerator
  localparam int DEN_W     = 14;  // unsigned denominator
  localparam int QUO_W     = 10;  // signed quotient
  localparam int MAG_W     = 23;  // numerator magnitude, holds 2^22
  localparam int RECIP_W   = 17;  // Q16 reciprocal, holds 65536
  localparam int FRAC_W    = 16;  // fraction bits of the reciprocal
  localparam int PROD_W    = DEN_W + RECIP_W;    // D*x
  localparam int TERM_W    = FRAC_W + 2;         // 2^17 - D*x, holds 2^17
  localparam int SCALE_W   = RECIP_W + TERM_W;   // x*(2^17 - D*x)
  localparam int QPROD_W   = MAG_W + RECIP_W;    // |N|*x2
  localparam int QRAW_W    = QPROD_W - FRAC_W;   // (|N|*x2) >> 16
  localparam int SAT_W     = QUO_W - 1;          // magnitude bits of the quotient
  localparam int LUT_MAX   = 64;
  localparam int LUT_IDX_W = 7;

  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = 7;

  localparam logic [TERM_W-1:0] TWO_Q16  = TERM_W'(2) << FRAC_W;
  localparam logic [QRAW_W-1:0] QUOT_MAX = QRAW_W'(511);

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             zero;
  } side_t;

  // Q16 reciprocal seeds of small denominators, approximately 65536/d.
  localparam logic [RECIP_W-1:0] SEED_LUT [LUT_MAX+1] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923,
    17'd9362,  17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,
    17'd4681,  17'd4369,  17'd4096,  17'd3855,  17'd3641,  17'd3449,  17'd3277,
    17'd3121,  17'd2979,  17'd2849,  17'd2731,  17'd2621,  17'd2521,  17'd2427,
    17'd2341,  17'd2256,  17'd2185,  17'd2115,  17'd2048,  17'd1986,  17'd1928,
    17'd1872,  17'd1820,  17'd1771,  17'd1725,  17'd1680,  17'd1638,  17'd1598,
    17'd1560,  17'd1524,  17'd1490,  17'd1457,  17'd1425,  17'd1395,  17'd1365,
    17'd1337,  17'd1311,  17'd1285,  17'd1260,  17'd1237,  17'd1214,  17'd1192,
    17'd1170,  17'd1150,  17'd1130,  17'd1111,  17'd1092,  17'd1074,  17'd1057,
    17'd1040,  17'd1024
  };

  // Small denominators use the table; larger ones get 2^(16-msb).
  function automatic logic [RECIP_W-1:0] seed_of(input logic [DEN_W-1:0] d);
    logic [RECIP_W-1:0] s;
    s = '0;
    if (d <= DEN_W'(LUT_MAX)) begin
      s = SEED_LUT[d[LUT_IDX_W-1:0]];
    end else begin
      // Ascending scan, so the highest set bit wins.
      for (int b = LUT_IDX_W - 1; b < DEN_W; b++) begin
        if (d[b]) begin
          s = RECIP_W'(1) << (FRAC_W - b);
        end
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/nrd_refine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Newton-Raphson refinement step
// One step x' = (x * (2^17 - D*x)) >> 16 over two register stages: the
// first forms D*x, the second the correction term and the scaled product.
// ----------------------------------------------------------------------------
module nrd_refine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [nrd_pkg::DEN_W-1:0]    den_i,
  input  wire logic [nrd_pkg::RECIP_W-1:0]  recip_i,
  input  wire nrd_pkg::side_t               side_i,
  output logic                              valid_o,
  output logic [nrd_pkg::DEN_W-1:0]         den_o,
  output logic [nrd_pkg::RECIP_W-1:0]       recip_o,
  output nrd_pkg::side_t                    side_o
);

  // Stage A: D*x.
  logic                          valid_a_q;
  logic [nrd_pkg::DEN_W-1:0]     den_a_q;
  logic [nrd_pkg::RECIP_W-1:0]   recip_a_q;
  nrd_pkg::side_t                side_a_q;
  logic [nrd_pkg::PROD_W-1:0]    prod_a_d, prod_a_q;

  // Stage B: refined reciprocal.
  logic                          valid_b_q;
  logic [nrd_pkg::DEN_W-1:0]     den_b_q;
  logic [nrd_pkg::RECIP_W-1:0]   recip_b_d, recip_b_q;
  nrd_pkg::side_t                side_b_q;
  logic [nrd_pkg::TERM_W-1:0]    term;
  logic [nrd_pkg::SCALE_W-1:0]   scaled;

  assign prod_a_d = nrd_pkg::PROD_W'(den_i) * nrd_pkg::PROD_W'(recip_i);

  always_comb begin
    // The term cannot go negative for these seeds; clamp it anyway.
    if (prod_a_q >= nrd_pkg::PROD_W'(nrd_pkg::TWO_Q16)) begin
      term = '0;
    end else begin
      term = nrd_pkg::TWO_Q16 - prod_a_q[nrd_pkg::TERM_W-1:0];
    end
    scaled    = nrd_pkg::SCALE_W'(recip_a_q) * nrd_pkg::SCALE_W'(term);
    // The refined value never exceeds 65536, so 17 bits hold it.
    recip_b_d = scaled[nrd_pkg::FRAC_W +: nrd_pkg::RECIP_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den_a_q   <= den_i;
    recip_a_q <= recip_i;
    side_a_q  <= side_i;
    prod_a_q  <= prod_a_d;
    den_b_q   <= den_a_q;
    recip_b_q <= recip_b_d;
    side_b_q  <= side_a_q;
  end

  assign valid_o = valid_b_q;
  assign den_o   = den_b_q;
  assign recip_o = recip_b_q;
  assign side_o  = side_b_q;

endmodule
`default_nettype wire

### hw/rtl/newton_raphson_signed_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Newton-Raphson signed divider
// Signed 23-bit numerator over unsigned 14-bit denominator, Q16 reciprocal
// seed refined by two Newton-Raphson steps, quotient saturated to +/-511.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ------------------------------------
//   input     start, busy               numerator_i[22:0], denominator_i[13:0]
//   result    result_valid_o (strobe)   quotient_o[9:0]
//
// A word is taken at every edge with start high; busy is always low.
// Results come out one per cycle, each through the seven register stages:
// seed, two stages per refinement step, the numerator multiply and the
// output register.
// Reset clears only the valid bits of the pipeline; no results are pending after it.
// The receiver has no back-pressure, so the pipeline never stalls.
//
module newton_raphson_signed_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [nrd_pkg::NUM_W-1:0]   numerator_i,
  input  wire logic [nrd_pkg::DEN_W-1:0]   denominator_i,
  output logic                             result_valid_o,
  output logic [nrd_pkg::QUO_W-1:0]       quotient_o
);

  // Stage 1: seed and numerator magnitude.
  logic                          valid_s1_q;
  logic [nrd_pkg::DEN_W-1:0]     den_s1_q;
  logic [nrd_pkg::RECIP_W-1:0]   seed_s1_d, seed_s1_q;
  nrd_pkg::side_t                side_s1_d, side_s1_q;

  // After first and second refinement.
  logic                          valid_r1, valid_r2;
  logic [nrd_pkg::DEN_W-1:0]     den_r1, den_r2;
  logic [nrd_pkg::RECIP_W-1:0]   recip_r1, recip_r2;
  nrd_pkg::side_t                side_r1, side_r2;

  // Stage 6: |N| * x2 >> 16.
  logic                          valid_s6_q;
  nrd_pkg::side_t                side_s6_q;
  logic [nrd_pkg::QPROD_W-1:0]   qprod;
  logic [nrd_pkg::QRAW_W-1:0]    qraw_s6_d, qraw_s6_q;

  // Stage 7: saturation and sign.
  logic                          valid_s7_q;
  logic [nrd_pkg::SAT_W-1:0]     qmag;
  logic [nrd_pkg::QUO_W-1:0]     quot_s7_d, quot_s7_q;

  assign busy = 1'b0;

  always_comb begin
    seed_s1_d      = nrd_pkg::seed_of(denominator_i);
    side_s1_d.neg  = numerator_i[nrd_pkg::NUM_W-1];
    // Two's complement negate; the most negative value yields 2^22 exactly.
    side_s1_d.mag  = side_s1_d.neg ? nrd_pkg::MAG_W'(~numerator_i + 1'b1)
                                   : nrd_pkg::MAG_W'(numerator_i);
    side_s1_d.zero = (denominator_i == '0) || (numerator_i == '0);
  end

  always_ff @(posedge clk_i) begin
    den_s1_q  <= denominator_i;
    seed_s1_q <= seed_s1_d;
    side_s1_q <= side_s1_d;
  end

  nrd_refine u_refine_1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s1_q),
    .den_i   (den_s1_q),
    .recip_i (seed_s1_q),
    .side_i  (side_s1_q),
    .valid_o (valid_r1),
    .den_o   (den_r1),
    .recip_o (recip_r1),
    .side_o  (side_r1)
  );

  nrd_refine u_refine_2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_r1),
    .den_i   (den_r1),
    .recip_i (recip_r1),
    .side_i  (side_r1),
    .valid_o (valid_r2),
    .den_o   (den_r2),
    .recip_o (recip_r2),
    .side_o  (side_r2)
  );

  assign qprod     = nrd_pkg::QPROD_W'(side_r2.mag) * nrd_pkg::QPROD_W'(recip_r2);
  assign qraw_s6_d = qprod[nrd_pkg::QPROD_W-1:nrd_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    qraw_s6_q <= qraw_s6_d;
    side_s6_q <= side_r2;
  end

  always_comb begin
    if (qraw_s6_q > nrd_pkg::QUOT_MAX) begin
      qmag = nrd_pkg::QUOT_MAX[nrd_pkg::SAT_W-1:0];
    end else begin
      qmag = qraw_s6_q[nrd_pkg::SAT_W-1:0];
    end
    if (side_s6_q.zero) begin
      quot_s7_d = '0;
    end else if (side_s6_q.neg) begin
      quot_s7_d = nrd_pkg::QUO_W'(0) - nrd_pkg::QUO_W'(qmag);
    end else begin
      quot_s7_d = nrd_pkg::QUO_W'(qmag);
    end
  end

  always_ff @(posedge clk_i) begin
    quot_s7_q <= quot_s7_d;
  end

  // den_r2 is unused past the second step; fold it into nothing but keep it
  // visible for debug through the valid path below.
  logic den_r2_nz;
  assign den_r2_nz = |den_r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s6_q <= 1'b0;
      valid_s7_q <= 1'b0;
    end else begin
      valid_s1_q <= start;
      valid_s6_q <= valid_r2 & (den_r2_nz | ~den_r2_nz);
      valid_s7_q <= valid_s6_q;
    end
  end

  assign result_valid_o = valid_s7_q;
  assign quotient_o     = quot_s7_q;

endmodule
`default_nettype wire

### hw/rtl/nrd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Newton-Raphson divider port checker
// Watches the divider's ports for fixed latency, no spurious results, a zero
// quotient for a zero operand and in-range quotients; bound to the top level below.
// ----------------------------------------------------------------------------
module nrd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [nrd_pkg::NUM_W-1:0]   numerator_i,
  input wire logic [nrd_pkg::DEN_W-1:0]   denominator_i,
  input wire logic                        result_valid_o,
  input wire logic [nrd_pkg::QUO_W-1:0]  quotient_o
);

  localparam logic [nrd_pkg::QUO_W-1:0] QUO_MIN_BAD = nrd_pkg::QUO_W'(1) << (nrd_pkg::QUO_W - 1);

  // Every accepted word produces a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(nrd_pkg::LATENCY) result_valid_o)
    else $error("accepted word produced no result");

  // No result without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && rst_ni, nrd_pkg::LATENCY))
    else $error("result strobe without an accepted word");

  // A zero denominator or numerator gives a zero quotient.
  a_zero_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (denominator_i == '0 || numerator_i == '0))
      |-> ##(nrd_pkg::LATENCY) (quotient_o == '0))
    else $error("zero operand gave a nonzero quotient");

  // Saturation keeps the quotient within -511..511.
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (quotient_o != QUO_MIN_BAD))
    else $error("quotient outside the saturation range");

endmodule

bind newton_raphson_signed_divider nrd_checker u_nrd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .numerator_i    (numerator_i),
  .denominator_i  (denominator_i),
  .result_valid_o (result_valid_o),
  .quotient_o     (quotient_o)
);
`default_nettype wire
